@@ rtl/tw_pkg.sv @@
// Package for the planar twist integrator: constants, word type carried along
// the cell chain and small helper functions. No dependencies.
`default_nettype none
package tw_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ROT_STEPS     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   // cell chain layout
   localparam int REM_STEPS    = 13;   // angle reduction, 2*pi << 12 down to << 0
   localparam int BAM_PREP     = 13;   // wrap to (-pi, pi], theta rounding
   localparam int BAM_FIRST    = 14;   // 32 quotient bits of angle to binary angle
   localparam int CORDIC_PREP  = 46;   // quadrant fold
   localparam int CORDIC_FIRST = 47;
   localparam int DIV_STEPS    = 48;   // center divider, one quotient bit per cell
   localparam int NUM_CELLS    = CORDIC_FIRST + ROT_STEPS;
   localparam int STAGE_W      = $clog2(NUM_CELLS + 1);

   localparam logic [63:0] TWO_PI_Q32   = 64'd26986075409;
   localparam logic [35:0] TWO_PI_Q32_N = 36'd26986075409;
   localparam logic [35:0] PI_Q32_N     = 36'd13493037704;
   localparam logic [63:0] TWO_PI_Q28   = 64'd1686629713;
   localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
   localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
   localparam logic [16:0] THRESH_RESET = 17'd655;

   localparam logic [31:0] ARC_TABLE [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic               curved;
      logic               w_neg;
      logic [31:0]        lin_x;
      logic [31:0]        lin_y;
      logic [63:0]        arem;     // angle remainder, then binary-angle dividend
      logic               r_neg;
      logic signed [18:0] theta;
      logic [31:0]        bam_q;
      logic signed [33:0] z;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic               flip;
      logic [31:0]        div_d;    // |w|
      logic [32:0]        rem_x;
      logic [32:0]        rem_y;
      logic [47:0]        nq_x;     // dividend bits out, quotient bits in
      logic [47:0]        nq_y;
      logic               neg_x;
      logic               neg_y;
   } tw_word_type;

   // signed saturation of a sign/magnitude quotient
   function automatic logic signed [31:0] sat_quot(input logic [47:0] q, input logic neg);
      logic [47:0] nq;
      nq = 48'd0 - q;
      if (neg) begin
         sat_quot = (q > 48'h0000_8000_0000) ? 32'sh8000_0000 : $signed(nq[31:0]);
      end else begin
         sat_quot = (q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      end
   endfunction

   function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
      if (v > ONE_Q30) begin
         clamp_unit = 32'(ONE_Q30);
      end else if (v < -ONE_Q30) begin
         clamp_unit = -32'(ONE_Q30);
      end else begin
         clamp_unit = v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ rtl/tw_req_if.sv @@
// Input channel of the twist integrator: one twist word per handshake.
// No dependencies.
`default_nettype none
interface tw_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angular_rate;
   logic signed [31:0] linear_x;
   logic signed [31:0] linear_y;
   modport source (output valid, angular_rate, linear_x, linear_y, input ready);
   modport sink (input valid, angular_rate, linear_x, linear_y, output ready);
endinterface
`default_nettype wire

@@ rtl/tw_rsp_if.sv @@
// Result channel of the twist integrator: one transform word per handshake.
// No dependencies.
`default_nettype none
interface tw_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] delta_theta;
   logic signed [31:0] delta_x;
   logic signed [31:0] delta_y;
   modport source (output valid, delta_theta, delta_x, delta_y, input ready);
   modport sink (input valid, delta_theta, delta_x, delta_y, output ready);
endinterface
`default_nettype wire

@@ rtl/tw_csr_if.sv @@
// Threshold write channel of the twist integrator.
// No dependencies.
`default_nettype none
interface tw_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] turn_threshold;
   modport source (output valid, turn_threshold, input ready);
   modport sink (input valid, turn_threshold, output ready);
endinterface
`default_nettype wire

@@ rtl/twist_integrator_2d_core.sv @@
// Top level of the planar twist integrator: entry logic, cell chain, and the
// product / rounding stages. Uses tw_pkg, tw_req_if, tw_rsp_if, tw_csr_if, tw_cell.
//
//   channel   dir  word
//   req_chan  in   angular_rate, linear_x, linear_y (Q16.16)
//   rsp_chan  out  delta_theta (19 bits, 16 fraction bits), delta_x, delta_y (Q16.16)
//   csr_chan  in   turn_threshold (Q16.16, 17 bits)
//
// One word accepted per cycle while the output is not stalled. In the cell chain,
// 48 divider bits run alongside angle reduction, binary-angle division and the
// CORDIC rotations; the product and rounding registers follow the chain.
// A stalled output holds the whole pipeline; req_chan.ready follows that.
// Reset empties the pipeline and sets the threshold to 655.
`default_nettype none
module twist_integrator_2d_core
   import tw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tw_req_if.sink    req_chan,
   tw_rsp_if.source  rsp_chan,
   tw_csr_if.sink    csr_chan
);

   logic [16:0] thresh_ff;
   logic        advance;
   tw_word_type entry_word;
   logic        cell_valid [NUM_CELLS];
   tw_word_type cell_word  [NUM_CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_chan.valid) begin
         thresh_ff <= csr_chan.turn_threshold;
      end
   end
   assign csr_chan.ready = 1'b1;

   logic out_valid_ff;
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      logic [32:0] wm, xm, ym;
      logic        vx_pos;
      wm = req_chan.angular_rate[31] ? 33'd0 - {1'b1, req_chan.angular_rate}
                                     : {1'b0, req_chan.angular_rate};
      xm = req_chan.linear_x[31] ? 33'd0 - {1'b1, req_chan.linear_x}
                                 : {1'b0, req_chan.linear_x};
      ym = req_chan.linear_y[31] ? 33'd0 - {1'b1, req_chan.linear_y}
                                 : {1'b0, req_chan.linear_y};
      vx_pos = !req_chan.linear_x[31] && (req_chan.linear_x != '0);
      entry_word        = '0;
      entry_word.curved = wm > {16'd0, thresh_ff};
      entry_word.w_neg  = req_chan.angular_rate[31];
      entry_word.lin_x  = req_chan.linear_x;
      entry_word.lin_y  = req_chan.linear_y;
      entry_word.arem   = {16'd0, wm[31:0], 16'd0};
      entry_word.div_d  = wm[31:0];
      entry_word.nq_x   = {ym[31:0], 16'd0};
      entry_word.nq_y   = {xm[31:0], 16'd0};
      entry_word.neg_x  = req_chan.linear_y[31] ^ req_chan.angular_rate[31];
      entry_word.neg_y  = vx_pos ^ req_chan.angular_rate[31];
   end

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      tw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (STAGE_W'(g)),
         .valid_in  ((g == 0) ? req_chan.valid : cell_valid[(g == 0) ? 0 : g - 1]),
         .word_in   ((g == 0) ? entry_word : cell_word[(g == 0) ? 0 : g - 1]),
         .valid_out (cell_valid[g]),
         .word_out  (cell_word[g])
      );
   end

   tw_word_type last_word;
   assign last_word = cell_word[NUM_CELLS-1];

   // stage A: saturate centers, finish sin/cos
   logic               va_ff, vb_ff, vc_ff;
   logic               ca_ff, cb_ff, cc_ff;
   logic signed [18:0] tha_ff, thb_ff, thc_ff;
   logic [31:0]        lxa_ff, lya_ff, lxb_ff, lyb_ff, lxc_ff, lyc_ff;
   logic signed [31:0] xs_ff, ys_ff, sn_ff;
   logic signed [32:0] cm1_ff;
   logic signed [64:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [65:0] sdx_ff, sdy_ff;
   logic signed [31:0] cs_in, sn_in;

   always_comb begin
      cs_in = clamp_unit(last_word.flip ? -last_word.x : last_word.x);
      sn_in = clamp_unit(last_word.flip ? -last_word.y : last_word.y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         va_ff        <= cell_valid[NUM_CELLS-1];
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         out_valid_ff <= vc_ff;
      end
   end

   logic signed [18:0] theta_ff;
   logic signed [31:0] dx_ff, dy_ff;
   logic signed [65:0] rdx, rdy;
   logic signed [35:0] shx, shy;
   logic signed [31:0] dx_in, dy_in;

   always_comb begin
      rdx = sdx_ff + 66'sd536870912;
      rdy = sdy_ff + 66'sd536870912;
      shx = 36'(rdx >>> 30);
      shy = 36'(rdy >>> 30);
      dx_in = (shx > 36'sd2147483647) ? 32'sh7FFF_FFFF :
              (shx < -36'sd2147483648) ? 32'sh8000_0000 : shx[31:0];
      dy_in = (shy > 36'sd2147483647) ? 32'sh7FFF_FFFF :
              (shy < -36'sd2147483648) ? 32'sh8000_0000 : shy[31:0];
      if (!cc_ff) begin
         dx_in = lxc_ff;
         dy_in = lyc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ca_ff  <= last_word.curved;
         tha_ff <= last_word.theta;
         lxa_ff <= last_word.lin_x;
         lya_ff <= last_word.lin_y;
         xs_ff  <= sat_quot(last_word.nq_x, last_word.neg_x);
         ys_ff  <= sat_quot(last_word.nq_y, last_word.neg_y);
         sn_ff  <= sn_in;
         cm1_ff <= 33'(cs_in) - 33'sd1073741824;

         cb_ff  <= ca_ff;
         thb_ff <= tha_ff;
         lxb_ff <= lxa_ff;
         lyb_ff <= lya_ff;
         p1_ff  <= 65'(xs_ff) * 65'(cm1_ff);
         p2_ff  <= 65'(ys_ff) * 65'(sn_ff);
         p3_ff  <= 65'(xs_ff) * 65'(sn_ff);
         p4_ff  <= 65'(ys_ff) * 65'(cm1_ff);

         cc_ff  <= cb_ff;
         thc_ff <= thb_ff;
         lxc_ff <= lxb_ff;
         lyc_ff <= lyb_ff;
         sdx_ff <= 66'(p1_ff) - 66'(p2_ff);
         sdy_ff <= 66'(p3_ff) + 66'(p4_ff);

         theta_ff <= cc_ff ? thc_ff : 19'sd0;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.delta_theta = theta_ff;
   assign rsp_chan.delta_x     = dx_ff;
   assign rsp_chan.delta_y     = dy_ff;

endmodule
`default_nettype wire

@@ rtl/tw_cell.sv @@
// One cell of the integrator chain: an angle step (reduction, binary angle or CORDIC,
// by position); cells below DIV_STEPS also step both center dividers. Uses tw_pkg.
`default_nettype none
module tw_cell
   import tw_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [STAGE_W-1:0] stage_idx,
   input  wire logic               valid_in,
   input  wire tw_word_type        word_in,
   output logic                    valid_out,
   output tw_word_type             word_out
);

   logic        valid_ff;
   tw_word_type word_ff, word_in_c;

   always_comb begin
      logic [STAGE_W-1:0] diff;
      logic [4:0]         sh;
      logic [63:0]        cmpv;
      logic [35:0]        a, t, rmag, rnd;
      logic signed [35:0] r;
      logic [19:0]        am;
      logic signed [33:0] zq, tx, ty;
      logic [32:0]        tr;
      word_in_c = word_in;
      diff = '0; sh = '0; cmpv = '0;
      a = '0; t = '0; rmag = '0; rnd = '0; r = '0; am = '0;
      zq = '0; tx = '0; ty = '0; tr = '0;

      priority if (stage_idx < STAGE_W'(REM_STEPS)) begin
         diff = STAGE_W'(REM_STEPS - 1) - stage_idx;
         sh   = diff[4:0];
         cmpv = TWO_PI_Q32 << sh;
         if (word_in.arem >= cmpv) begin
            word_in_c.arem = word_in.arem - cmpv;
         end
      end else if (stage_idx == STAGE_W'(BAM_PREP)) begin
         a = word_in.arem[35:0];
         t = TWO_PI_Q32_N - a;
         if (!word_in.w_neg) begin
            r = (a > PI_Q32_N) ? $signed(a - TWO_PI_Q32_N) : $signed(a);
         end else if (a == '0) begin
            r = '0;
         end else begin
            r = (t > PI_Q32_N) ? -$signed(a) : $signed(t);
         end
         rmag = r[35] ? 36'(-r) : 36'(r);
         rnd  = rmag + 36'd32768;
         am   = rnd[35:16];
         word_in_c.r_neg = r[35];
         word_in_c.theta = r[35] ? -$signed(am[18:0]) : $signed(am[18:0]);
         word_in_c.arem  = {rmag, 28'd0};
         word_in_c.bam_q = '0;
      end else if (stage_idx < STAGE_W'(CORDIC_PREP)) begin
         diff = STAGE_W'(BAM_FIRST + 31) - stage_idx;
         sh   = diff[4:0];
         cmpv = TWO_PI_Q28 << sh;
         if (word_in.arem >= cmpv) begin
            word_in_c.arem      = word_in.arem - cmpv;
            word_in_c.bam_q[sh] = 1'b1;
         end
      end else if (stage_idx == STAGE_W'(CORDIC_PREP)) begin
         zq = $signed({2'b00, word_in.bam_q});
         zq = word_in.r_neg ? -zq : zq;
         word_in_c.flip = 1'b0;
         if (zq > QUARTER_TURN) begin
            zq = zq - HALF_TURN;
            word_in_c.flip = 1'b1;
         end else if (zq < -QUARTER_TURN) begin
            zq = zq + HALF_TURN;
            word_in_c.flip = 1'b1;
         end
         word_in_c.z = zq;
         word_in_c.x = GAIN_Q30;
         word_in_c.y = '0;
      end else begin
         diff = stage_idx - STAGE_W'(CORDIC_FIRST);
         sh   = diff[4:0];
         ty   = word_in.y >>> sh;
         tx   = word_in.x >>> sh;
         if (word_in.z >= 0) begin
            word_in_c.x = word_in.x - ty;
            word_in_c.y = word_in.y + tx;
            word_in_c.z = word_in.z - $signed({2'b00, ARC_TABLE[sh]});
         end else begin
            word_in_c.x = word_in.x + ty;
            word_in_c.y = word_in.y - tx;
            word_in_c.z = word_in.z + $signed({2'b00, ARC_TABLE[sh]});
         end
      end

      // restoring division step, both centers
      if (stage_idx < STAGE_W'(DIV_STEPS)) begin
         tr = {word_in.rem_x[31:0], word_in.nq_x[47]};
         word_in_c.nq_x = {word_in.nq_x[46:0], 1'b0};
         if (tr >= {1'b0, word_in.div_d}) begin
            tr = tr - {1'b0, word_in.div_d};
            word_in_c.nq_x[0] = 1'b1;
         end
         word_in_c.rem_x = tr;
         tr = {word_in.rem_y[31:0], word_in.nq_y[47]};
         word_in_c.nq_y = {word_in.nq_y[46:0], 1'b0};
         if (tr >= {1'b0, word_in.div_d}) begin
            tr = tr - {1'b0, word_in.div_d};
            word_in_c.nq_y[0] = 1'b1;
         end
         word_in_c.rem_y = tr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for twist_integrator_2d_core: predicts each pose word
// from the twist word and compares it on the result channel.
// Depends on tw_pkg and the tw_req_if, tw_rsp_if, tw_csr_if interfaces.
`timescale 1ns / 100ps
module tb;
   import tw_pkg::*;

   typedef struct {
      logic signed [31:0] w;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } twist_type;

   typedef struct {
      logic signed [18:0] th;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
   } pose_type;

   localparam longint TWO_PI_FIX = 64'sd26986075409;
   localparam longint TWO_PI_BAM = 64'sd1686629713;
   localparam longint UNIT_Q30   = 64'sd1073741824;
   localparam longint K_GAIN     = 64'sd652032874;
   localparam int     IDLE_LIMIT = 2000;
   localparam int     DRAIN_CYC  = 70;
   localparam int     PHASE_LEN  = 275;

   localparam longint ATAN_BAM [32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
      'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
      'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
      'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
      'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005,
      'h00000003, 'h00000001, 'h00000001, 'h00000000
   };

   logic clock;
   logic reset;

   tw_req_if req_if ();
   tw_rsp_if rsp_if ();
   tw_csr_if csr_if ();

   twist_integrator_2d_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source),
      .csr_chan(csr_if.sink)
   );

   twist_type   twist_pending [$];
   pose_type    pose_expected [$];
   logic [16:0] turn_thr;
   int          errors;
   int          req_gap;
   int          rsp_stall;
   int          hold_len;
   int          idle_cycles;
   bit          burst;
   bit          hold_rsp;

   function automatic longint sat_q16(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp_q30(input longint v);
      if (v > UNIT_Q30) return UNIT_Q30;
      if (v < -UNIT_Q30) return -UNIT_Q30;
      return v;
   endfunction

   // SE(2) exponential of one twist at the current threshold
   function automatic pose_type twist_exp(input twist_type t, input logic [16:0] thr);
      pose_type p;
      longint w, vx, vy, mag, w32, r, am, xs, ys, sn, cs, cm1, z, x, y, tx, ty;
      bit     flip;
      w   = t.w;
      vx  = t.vx;
      vy  = t.vy;
      mag = (w < 0) ? -w : w;
      p.th = '0;
      p.dx = t.vx;
      p.dy = t.vy;
      if (mag > longint'(thr)) begin
         w32 = w * 65536;
         r = w32 - (w32 / TWO_PI_FIX) * TWO_PI_FIX;
         if (r < 0) r += TWO_PI_FIX;
         if (r > TWO_PI_FIX / 2) r -= TWO_PI_FIX;
         am = (r < 0) ? -r : r;
         am = (am + 32768) >>> 16;
         p.th = 19'((r < 0) ? -am : am);
         xs = sat_q16((vy * 65536) / w);
         ys = sat_q16((-vx * 65536) / w);
         // angle to binary units, quadrant fold, then rotate
         z = (r * 268435456) / TWO_PI_BAM;
         x = K_GAIN;
         y = 0;
         flip = 0;
         if (z > UNIT_Q30) begin
            z -= 2 * UNIT_Q30;
            flip = 1;
         end else if (z < -UNIT_Q30) begin
            z += 2 * UNIT_Q30;
            flip = 1;
         end
         for (int i = 0; i < ROT_STEPS; i++) begin
            ty = y >>> i;
            tx = x >>> i;
            if (z >= 0) begin
               x -= ty; y += tx; z -= ATAN_BAM[i];
            end else begin
               x += ty; y -= tx; z += ATAN_BAM[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         sn  = clamp_q30(y);
         cs  = clamp_q30(x);
         cm1 = cs - UNIT_Q30;
         p.dx = 32'(sat_q16((xs * cm1 - ys * sn + 536870912) >>> 30));
         p.dy = 32'(sat_q16((xs * sn + ys * cm1 + 536870912) >>> 30));
      end
      return p;
   endfunction

   function automatic logic signed [31:0] signed_upto(input int unsigned lim);
      logic signed [31:0] v;
      v = $urandom_range(lim, 0);
      return $urandom_range(1, 0) ? -v : v;
   endfunction

   function automatic twist_type random_twist(input logic [16:0] thr);
      twist_type t;
      t.w  = $urandom;
      t.vx = $urandom;
      t.vy = $urandom;
      case ($urandom_range(9, 0))
         0, 1, 2: ;
         3, 4, 5, 6: begin
            t.w  = signed_upto(8 * 65536);
            t.vx = signed_upto(1 << 24);
            t.vy = signed_upto(1 << 24);
         end
         7: t.w = signed_upto(3) + ($urandom_range(1, 0) ? -32'(thr) : 32'(thr));
         8: t.w = signed_upto(3);   // tiny rate: center saturates
         default: t.w = signed_upto(65536);
      endcase
      return t;
   endfunction

   task automatic add_twist(input logic signed [31:0] w, vx, vy);
      twist_type t;
      t.w = w; t.vx = vx; t.vy = vy;
      twist_pending.push_back(t);
   endtask

   task automatic write_threshold(input logic [16:0] v);
      csr_if.valid          <= 1'b1;
      csr_if.turn_threshold <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      turn_thr = v;
   endtask

   task automatic wait_drained();
      while (twist_pending.size() != 0 || req_if.valid || pose_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
         burst        <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            twist_type acc;
            acc.w  = req_if.angular_rate;
            acc.vx = req_if.linear_x;
            acc.vy = req_if.linear_y;
            pose_expected.push_back(twist_exp(acc, turn_thr));
            if ($urandom_range(63, 0) == 0) burst <= ~burst;
            if (burst && twist_pending.size() != 0) begin
               twist_type nxt;
               nxt = twist_pending.pop_front();
               req_if.angular_rate <= nxt.w;
               req_if.linear_x     <= nxt.vx;
               req_if.linear_y     <= nxt.vy;
            end else begin
               req_if.valid <= 1'b0;
               req_gap      <= burst ? 0 : $urandom_range(11, 0);
            end
         end else if (!req_if.valid) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
            end else if (twist_pending.size() != 0) begin
               twist_type nxt;
               nxt = twist_pending.pop_front();
               req_if.angular_rate <= nxt.w;
               req_if.linear_x     <= nxt.vx;
               req_if.linear_y     <= nxt.vy;
               req_if.valid        <= 1'b1;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
         hold_len     <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            pose_type e;
            if (pose_expected.size() == 0) begin
               $display("%0t: unexpected pose word th=%0d dx=%0d dy=%0d", $time,
                        rsp_if.delta_theta, rsp_if.delta_x, rsp_if.delta_y);
               errors++;
            end else begin
               e = pose_expected.pop_front();
               if (rsp_if.delta_theta !== e.th) begin
                  $display("%0t: delta_theta expected %0d actual %0d", $time, e.th,
                           rsp_if.delta_theta);
                  errors++;
               end
               if (rsp_if.delta_x !== e.dx) begin
                  $display("%0t: delta_x expected %0d actual %0d", $time, e.dx,
                           rsp_if.delta_x);
                  errors++;
               end
               if (rsp_if.delta_y !== e.dy) begin
                  $display("%0t: delta_y expected %0d actual %0d", $time, e.dy,
                           rsp_if.delta_y);
                  errors++;
               end
            end
         end
         if (hold_rsp && hold_len < 300) begin
            // long hold-off so the pipeline fills and backs up the input
            rsp_if.ready <= 1'b0;
            hold_len     <= hold_len + 1;
         end else if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
         end else if (rsp_if.valid && rsp_if.ready) begin
            if (burst) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               rsp_stall    <= $urandom_range(11, 0);
            end
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [16:0] thr_list [6];
      errors                = 0;
      turn_thr              = THRESH_RESET;
      hold_rsp              = 1'b0;
      idle_cycles           = 0;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.angular_rate   = '0;
      req_if.linear_x       = '0;
      req_if.linear_y       = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.turn_threshold = '0;
      thr_list = '{17'd655, 17'd0, 17'd65536, 17'd131071, 17'd0, 17'd0};
      thr_list[4] = $urandom_range(65536, 0);
      thr_list[5] = $urandom_range(2000, 1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: threshold edges, zero rate, angle wraps, field extremes
      add_twist(32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      add_twist(32'sd655, 32'sd65536, -32'sd65536);
      add_twist(-32'sd655, 32'sd65536, 32'sd65536);
      add_twist(32'sd656, 32'sd65536, 32'sd131072);
      add_twist(-32'sd656, -32'sd65536, 32'sd131072);
      add_twist(32'sd205887, 32'sd65536, 32'sd0);
      add_twist(-32'sd205887, 32'sd0, 32'sd65536);
      add_twist(32'sd205888, 32'sd65536, 32'sd65536);
      add_twist(32'sd411775, -32'sd65536, 32'sd65536);
      add_twist(32'sd102944, 32'sd65536, 32'sd0);
      add_twist(-32'sd102944, 32'sd0, -32'sd65536);
      add_twist(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_twist(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      add_twist(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
      add_twist(32'sd656, 32'sh8000_0000, 32'sh7FFF_FFFF);   // center overflow
      add_twist(-32'sd700, 32'sh7FFF_FFFF, 32'sh8000_0000);
      add_twist(32'sd65536, 32'sd0, 32'sd0);
      add_twist(32'sd3, 32'sd1, -32'sd1);
      add_twist(-32'sd1, 32'shFFFF_FFFF, 32'sd0);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph != 0) write_threshold(thr_list[ph]);
         for (int n = 0; n < PHASE_LEN; n++) twist_pending.push_back(random_twist(turn_thr));
         if (ph == 2) hold_rsp = 1'b1;
         wait_drained();
      end

      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
